/* hdl/i2c_master_bus_sequencer_assert.svh */
// Assertion macros used by the checker file.
`ifndef I2C_MASTER_BUS_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_BUS_SEQUENCER_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge
`define I2CM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cm assertion failed");

// Next-cycle implication, sampled on the rising clock edge
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cm assertion failed");

`endif

/* hdl/i2cm_pkg.sv */
package i2cm_pkg;

   // Bus commands
   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_START  = 3'd1,
      CMD_RSTART = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_WRITE  = 3'd4,
      CMD_READ   = 3'd5,
      CMD_ACK    = 3'd6,
      CMD_NACK   = 3'd7
   } cmd_type;

   localparam int unsigned BIT_COUNT = 8;
   localparam int unsigned TOP_BIT   = 7;
   localparam int unsigned PHASE_W   = 5;

   // Write: three phases per bit, then release SDA, sample ack, drop SCL
   localparam logic [PHASE_W-1:0] WR_RELEASE_PHASE = PHASE_W'(BIT_COUNT * 3);
   localparam logic [PHASE_W-1:0] WR_SAMPLE_PHASE  = PHASE_W'(BIT_COUNT * 3 + 1);
   localparam logic [PHASE_W-1:0] WR_LAST_PHASE    = PHASE_W'(BIT_COUNT * 3 + 2);
   // Read: two phases per bit
   localparam logic [PHASE_W-1:0] RD_PHASES        = PHASE_W'(BIT_COUNT * 2);

   // Short sequences, two bits per step {line, level}, line 1 = SDA, step 0 lowest
   localparam logic [7:0] SEQ_START  = {2'b00, 2'b00, 2'b01, 2'b10};
   localparam logic [7:0] SEQ_RSTART = {2'b00, 2'b10, 2'b01, 2'b11};
   localparam logic [7:0] SEQ_STOP   = {2'b11, 2'b01, 2'b10, 2'b00};
   localparam logic [7:0] SEQ_ACK    = {2'b11, 2'b00, 2'b01, 2'b10};
   localparam logic [7:0] SEQ_NACK   = {2'b11, 2'b00, 2'b01, 2'b11};
   localparam logic [2:0] LEN_START  = 3'd3;
   localparam logic [2:0] LEN_SHORT  = 3'd4;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] data_byte;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_data;
      logic       nak_received;
   } rsp_type;

endpackage

/* hdl/i2cm_core.sv */
module i2cm_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  i2cm_pkg::req_type req_word,
   output i2cm_pkg::rsp_type rsp_word
);
   import i2cm_pkg::*;

   cmd_type              active_ff, active_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [7:0]           shift_ff, shift_in;
   logic [7:0]           read_ff, read_in;
   logic                 ack_ff, ack_in;
   logic                 scl_ff, scl_in;
   logic                 sda_ff, sda_in;

   cmd_type              cmd;
   cmd_type              act;
   logic                 take;
   logic [PHASE_W-1:0]   p;
   logic                 running;
   logic                 last;
   logic [7:0]           seq_bits;
   logic [2:0]           seq_len;
   logic [1:0]           entry;
   logic [8:0]           div_prod;
   logic [3:0]           bit_index;
   logic [PHASE_W-1:0]   bit_phase;

   // Decode command and pick the current phase
   always_comb begin
      cmd  = cmd_type'(req_word.command);
      take = (active_ff == CMD_NONE) && (cmd != CMD_NONE);
      act  = take ? cmd : active_ff;
      p    = take ? '0 : phase_ff;
   end

   // Phase within a write bit: p mod 3 through multiply by 11/32
   always_comb begin
      div_prod  = 9'(p) * 9'd11;
      bit_index = div_prod[8:5];
      bit_phase = p - PHASE_W'({bit_index, 1'b0}) - PHASE_W'(bit_index);
   end

   // Select the short sequence table
   always_comb begin
      case (act)
         CMD_START: begin
            seq_bits = SEQ_START;
            seq_len  = LEN_START;
         end
         CMD_RSTART: begin
            seq_bits = SEQ_RSTART;
            seq_len  = LEN_SHORT;
         end
         CMD_STOP: begin
            seq_bits = SEQ_STOP;
            seq_len  = LEN_SHORT;
         end
         CMD_ACK: begin
            seq_bits = SEQ_ACK;
            seq_len  = LEN_SHORT;
         end
         CMD_NACK: begin
            seq_bits = SEQ_NACK;
            seq_len  = LEN_SHORT;
         end
         default: begin
            seq_bits = SEQ_START;
            seq_len  = LEN_START;
         end
      endcase
      entry = seq_bits[{p[1:0], 1'b0} +: 2];
   end

   // Run one phase of the active sequence
   always_comb begin
      shift_in  = (take && cmd == CMD_WRITE) ? req_word.data_byte : shift_ff;
      read_in   = (take && cmd == CMD_READ) ? 8'd0 : read_ff;
      ack_in    = ack_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      running   = 1'b1;
      last      = 1'b0;
      case (act)
         CMD_NONE: begin
            running = 1'b0;
         end
         CMD_WRITE: begin
            if (p < WR_RELEASE_PHASE) begin
               case (bit_phase[1:0])
                  2'd0: sda_in = shift_in[TOP_BIT];
                  2'd1: scl_in = 1'b1;
                  default: begin
                     scl_in   = 1'b0;
                     shift_in = {shift_in[6:0], 1'b0};
                  end
               endcase
            end else if (p == WR_RELEASE_PHASE) begin
               sda_in = 1'b1;
            end else if (p == WR_SAMPLE_PHASE) begin
               scl_in = 1'b1;
               ack_in = req_word.sda_in;
            end else if (p == WR_LAST_PHASE) begin
               scl_in = 1'b0;
               last   = 1'b1;
            end else begin
               last = 1'b1;
            end
         end
         CMD_READ: begin
            if (p >= RD_PHASES) begin
               last = 1'b1;
            end else if (!p[0]) begin
               scl_in  = 1'b1;
               read_in = {read_in[6:0], req_word.sda_in};
            end else begin
               scl_in = 1'b0;
               last   = (p == RD_PHASES - PHASE_W'(1));
            end
         end
         default: begin
            if (p >= PHASE_W'(seq_len)) begin
               last = 1'b1;
            end else begin
               if (entry[1]) begin
                  sda_in = entry[0];
               end else begin
                  scl_in = entry[0];
               end
               last = (p == PHASE_W'(seq_len) - PHASE_W'(1));
            end
         end
      endcase
      // Advance or close the sequence
      if (running && last) begin
         active_in = CMD_NONE;
         phase_in  = '0;
      end else if (running) begin
         active_in = act;
         phase_in  = p + PHASE_W'(1);
      end else begin
         active_in = active_ff;
         phase_in  = phase_ff;
      end
   end

   // Result word for this phase
   always_comb begin
      rsp_word.scl_level    = scl_in;
      rsp_word.sda_level    = sda_in;
      rsp_word.busy_res     = running && !last;
      rsp_word.done_res     = running && last;
      rsp_word.read_data    = read_in;
      rsp_word.nak_received = ack_in;
   end

   // Commit state on each processed word
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= CMD_NONE;
         phase_ff  <= '0;
         shift_ff  <= '0;
         read_ff   <= '0;
         ack_ff    <= 1'b0;
         scl_ff    <= 1'b1;
         sda_ff    <= 1'b1;
      end else if (step) begin
         active_ff <= active_in;
         phase_ff  <= phase_in;
         shift_ff  <= shift_in;
         read_ff   <= read_in;
         ack_ff    <= ack_in;
         scl_ff    <= scl_in;
         sda_ff    <= sda_in;
      end
   end

endmodule

/* hdl/i2c_master_bus_sequencer.sv */
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_ready  req_data: command, data_byte, sda_in
// rsp_      out        rsp_valid / rsp_ready  rsp_data: scl, sda, busy, done, read, nak
//
// One word per clock cycle sustained while rsp_ is not stalled; a result is offered
// on rsp_ once its word has gone through the input register, then one pass of phase logic
// into the output register. Synchronous active-high reset empties both registers and
// returns the sequencer to idle with both lines released. A stall on rsp_
// holds the result; the input register takes one more word, then req_ready drops.
module i2c_master_bus_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2cm_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   logic    req_valid_ff, req_valid_in;
   req_type req_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_word;
   logic    out_free;
   logic    step;

   // Advance when the output register can take a word
   always_comb begin
      out_free     = !rsp_valid_ff || rsp_ready;
      step         = req_valid_ff && out_free;
      req_ready    = !req_valid_ff || out_free;
      req_valid_in = (req_valid && req_ready) || (req_valid_ff && !out_free);
      rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);
   end

   i2cm_core u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (step),
      .req_word (req_data_ff),
      .rsp_word (core_word)
   );

   // Hold valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_data_ff <= req_data;
      end
      if (step) begin
         rsp_data_ff <= core_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/i2cm_checker.sv */
`include "i2c_master_bus_sequencer_assert.svh"

module i2cm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input i2cm_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input i2cm_pkg::rsp_type rsp_data
);
   import i2cm_pkg::*;

   // A phase is either still running or the last one, never both
   `I2CM_ASSERT_IMPLY(a_busy_done_excl, clock, reset, rsp_valid, !(rsp_data.busy_res && rsp_data.done_res))
   // Reset empties the output register
   `I2CM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // Free output side always leaves room for a new word
   `I2CM_ASSERT_IMPLY(a_ready_follows, clock, reset, rsp_ready, req_ready)
   // Stalled result stays put
   `I2CM_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   // Offered word waits unchanged until taken
   `I2CM_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_data))

endmodule

bind i2c_master_bus_sequencer i2cm_checker u_checker (.*);

/* dv/tb.sv */
`timescale 1ns / 1ps

module tb;
   import i2cm_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 420;
   localparam int DRAIN_CYCLES = 12;
   localparam int PRINT_LIMIT  = 40;

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   // hand-typed expectation riding along with the word being offered
   logic    word_typed;
   rsp_type word_typed_rsp;

   int gap_pct   = 33;
   int stall_pct = 33;
   int words_sent;
   int results_seen;
   int mismatches;
   int cycles;
   int started_by_cmd [8];

   rsp_type line_expect_q [$];

   // predictor state
   logic [4:0] bus_phase  = '0;
   cmd_type    bus_cmd    = CMD_NONE;
   logic [7:0] tx_shift   = '0;
   logic [7:0] rx_byte    = '0;
   logic       ack_seen   = 1'b0;
   logic       scl_out    = 1'b1;
   logic       sda_out    = 1'b1;

   typedef struct {
      cmd_type    cmd;
      logic [7:0] data;
      logic [7:0] sda_pat;
      int         ticks;
      cmd_type    busy_cmd;
      bit         typed;
      rsp_type    exp;
   } step_row;

   // directed plan: one row per command, sda_in taken from sda_pat by tick
   step_row plan [19] = '{
      '{CMD_NONE,   8'h00, 8'h00,  1, CMD_NONE,  1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0}},
      '{CMD_START,  8'h00, 8'h00,  3, CMD_NONE,  1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 8'h00, 1'b0}},
      '{CMD_WRITE,  8'hFF, 8'hFF, 27, CMD_STOP,  1'b0, '0},
      '{CMD_WRITE,  8'h00, 8'h00, 27, CMD_READ,  1'b0, '0},
      '{CMD_WRITE,  8'hA5, 8'h55, 27, CMD_NONE,  1'b0, '0},
      '{CMD_READ,   8'h00, 8'hFF, 16, CMD_WRITE, 1'b0, '0},
      '{CMD_READ,   8'hFF, 8'h00, 16, CMD_NONE,  1'b0, '0},
      '{CMD_READ,   8'h3C, 8'hB2, 16, CMD_NACK,  1'b0, '0},
      '{CMD_ACK,    8'h00, 8'h00,  4, CMD_NACK,  1'b0, '0},
      '{CMD_NACK,   8'h00, 8'hFF,  4, CMD_NONE,  1'b0, '0},
      '{CMD_RSTART, 8'h00, 8'h00,  4, CMD_ACK,   1'b0, '0},
      '{CMD_STOP,   8'h00, 8'h00,  4, CMD_START, 1'b0, '0},
      '{CMD_NONE,   8'h5A, 8'hA5,  3, CMD_NONE,  1'b0, '0},
      '{CMD_START,  8'h00, 8'h00,  3, CMD_RSTART,1'b0, '0},
      '{CMD_WRITE,  8'h80, 8'h0F, 27, CMD_NONE,  1'b0, '0},
      '{CMD_READ,   8'h01, 8'h6D, 16, CMD_NONE,  1'b0, '0},
      '{CMD_NACK,   8'h00, 8'h00,  4, CMD_NONE,  1'b0, '0},
      '{CMD_STOP,   8'h00, 8'h00,  4, CMD_NONE,  1'b0, '0},
      '{CMD_STOP,   8'h7F, 8'h80,  4, CMD_NONE,  1'b0, '0}
   };

   i2c_master_bus_sequencer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // number of phase ticks a command occupies
   function automatic int phase_ticks(cmd_type c);
      case (c)
         CMD_NONE:  return 1;
         CMD_START: return 3;
         CMD_WRITE: return 27;
         CMD_READ:  return 16;
         default:   return 4;
      endcase
   endfunction

   // short sequences: {drives sda, level} for each phase
   function automatic logic [1:0] short_phase(cmd_type c, logic [4:0] p);
      logic [1:0] s [4];
      case (c)
         CMD_START:  s = '{2'b10, 2'b01, 2'b00, 2'b00};
         CMD_RSTART: s = '{2'b11, 2'b01, 2'b10, 2'b00};
         CMD_STOP:   s = '{2'b00, 2'b10, 2'b01, 2'b11};
         CMD_ACK:    s = '{2'b10, 2'b01, 2'b00, 2'b11};
         default:    s = '{2'b11, 2'b01, 2'b00, 2'b11};
      endcase
      return s[p[1:0]];
   endfunction

   // advance the bus sequencer by one phase tick and report the line levels
   function automatic rsp_type step_bus(req_type w);
      logic       run;
      logic       fin;
      logic [1:0] ent;
      rsp_type    r;
      run = 1'b0;
      fin = 1'b0;
      if (bus_cmd == CMD_NONE && w.command != CMD_NONE) begin
         bus_cmd   = cmd_type'(w.command);
         bus_phase = '0;
         started_by_cmd[w.command]++;
         if (bus_cmd == CMD_WRITE) tx_shift = w.data_byte;
         if (bus_cmd == CMD_READ) rx_byte = '0;
      end
      if (bus_cmd != CMD_NONE) begin
         run = 1'b1;
         case (bus_cmd)
            CMD_WRITE: begin
               if (bus_phase < 5'd24) begin
                  case (bus_phase % 3)
                     0: sda_out = tx_shift[7];
                     1: scl_out = 1'b1;
                     default: begin
                        scl_out  = 1'b0;
                        tx_shift = {tx_shift[6:0], 1'b0};
                     end
                  endcase
               end else if (bus_phase == 5'd24) begin
                  sda_out = 1'b1;
               end else if (bus_phase == 5'd25) begin
                  scl_out  = 1'b1;
                  ack_seen = w.sda_in;
               end else begin
                  if (bus_phase == 5'd26) scl_out = 1'b0;
                  fin = 1'b1;
               end
            end
            CMD_READ: begin
               if (bus_phase >= 5'd16) begin
                  fin = 1'b1;
               end else if (!bus_phase[0]) begin
                  scl_out = 1'b1;
                  rx_byte = {rx_byte[6:0], w.sda_in};
               end else begin
                  scl_out = 1'b0;
                  fin     = (bus_phase == 5'd15);
               end
            end
            default: begin
               if (bus_phase >= phase_ticks(bus_cmd)) begin
                  fin = 1'b1;
               end else begin
                  ent = short_phase(bus_cmd, bus_phase);
                  if (ent[1]) sda_out = ent[0];
                  else scl_out = ent[0];
                  fin = (bus_phase + 1 == phase_ticks(bus_cmd));
               end
            end
         endcase
         if (fin) begin
            bus_cmd   = CMD_NONE;
            bus_phase = '0;
         end else begin
            bus_phase = bus_phase + 5'd1;
         end
      end
      r.scl_level    = scl_out;
      r.sda_level    = sda_out;
      r.busy_res     = run && !fin;
      r.done_res     = run && fin;
      r.read_data    = rx_byte;
      r.nak_received = ack_seen;
      return r;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      end
   endtask

   // offer one word at the falling edge, hold it until taken
   task automatic send_word(req_type w, bit typed, rsp_type typed_rsp);
      if ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_data       <= w;
      word_typed     <= typed;
      word_typed_rsp <= typed_rsp;
      do @(posedge clock); while (!(req_valid && req_ready));
      words_sent++;
      @(negedge clock);
   endtask

   // run one command through all its ticks, with stray commands while busy
   task automatic run_cmd(cmd_type c, logic [7:0] d, int noise_pct);
      req_type w;
      for (int t = 0; t < phase_ticks(c); t++) begin
         if (t == 0)
            w.command = c;
         else if ($urandom_range(0, 99) < noise_pct)
            w.command = 3'($urandom_range(0, 7));
         else
            w.command = CMD_NONE;
         w.data_byte = (t == 0) ? d : 8'($urandom_range(0, 255));
         w.sda_in    = 1'($urandom_range(0, 1));
         send_word(w, 1'b0, '0);
      end
   endtask

   // well-formed transfer: start, address, data bytes, then stop or restart
   task automatic run_transfer();
      run_cmd(CMD_START, 8'($urandom_range(0, 255)), 10);
      run_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 10);
      repeat ($urandom_range(0, 3)) begin
         if ($urandom_range(0, 1)) begin
            run_cmd(CMD_WRITE, 8'($urandom_range(0, 255)), 10);
         end else begin
            run_cmd(CMD_READ, 8'($urandom_range(0, 255)), 10);
            run_cmd($urandom_range(0, 1) ? CMD_ACK : CMD_NACK, 8'($urandom_range(0, 255)), 10);
         end
      end
      run_cmd($urandom_range(0, 4) == 0 ? CMD_RSTART : CMD_STOP, 8'($urandom_range(0, 255)), 10);
   endtask

   // score results against the predictor, then queue the next expectation
   always @(posedge clock) begin : score
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (line_expect_q.size() == 0) begin
               mismatches++;
               $display("%0t: result with nothing expected, expected none actual %0h",
                        $time, rsp_data);
            end else begin
               want = line_expect_q.pop_front();
               check_field("scl_level", want.scl_level, rsp_data.scl_level);
               check_field("sda_level", want.sda_level, rsp_data.sda_level);
               check_field("busy_res", want.busy_res, rsp_data.busy_res);
               check_field("done_res", want.done_res, rsp_data.done_res);
               check_field("read_data", want.read_data, rsp_data.read_data);
               check_field("nak_received", want.nak_received, rsp_data.nak_received);
            end
         end
         if (req_valid && req_ready) begin
            want = step_bus(req_data);
            if (word_typed) want = word_typed_rsp;
            line_expect_q.push_back(want);
         end
      end
   end

   // receiver stalls
   always @(negedge clock) begin
      if (!reset) rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, line_expect_q.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin : stimulus
      req_type w;
      int      base;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      word_typed     = 1'b0;
      word_typed_rsp = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed walk through the plan
      foreach (plan[i]) begin
         for (int t = 0; t < plan[i].ticks; t++) begin
            w.command   = (t == 0) ? plan[i].cmd : plan[i].busy_cmd;
            w.data_byte = plan[i].data;
            w.sda_in    = plan[i].sda_pat[t % 8];
            send_word(w, plan[i].typed && (t == plan[i].ticks - 1), plan[i].exp);
         end
      end

      // random traffic, with a quiet stretch free of gaps and stalls
      base = words_sent;
      while (words_sent - base < RANDOM_WORDS) begin
         if (words_sent - base >= 150 && words_sent - base < 300) begin
            gap_pct   = 0;
            stall_pct = 0;
         end else begin
            gap_pct   = 33;
            stall_pct = 33;
         end
         case ($urandom_range(0, 99)) inside
            [0:69]:  run_transfer();
            [70:84]: repeat ($urandom_range(1, 4))
                        run_cmd(cmd_type'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), 30);
            default: repeat ($urandom_range(1, 3))
                        run_cmd(CMD_NONE, 8'($urandom_range(0, 255)), 0);
         endcase
      end
      req_valid <= 1'b0;

      // drain outstanding results, then watch for strays
      while (line_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Drove %0d phase words and checked %0d results; commands started:",
               words_sent, results_seen);
      $display("  start %0d rstart %0d stop %0d write %0d read %0d ack %0d nack %0d",
               started_by_cmd[CMD_START], started_by_cmd[CMD_RSTART],
               started_by_cmd[CMD_STOP], started_by_cmd[CMD_WRITE],
               started_by_cmd[CMD_READ], started_by_cmd[CMD_ACK],
               started_by_cmd[CMD_NACK]);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/i2cm_pkg.sv
hdl/i2cm_core.sv
hdl/i2c_master_bus_sequencer.sv
hdl/i2cm_checker.sv
dv/tb.sv
